>>> hw/rtl/synapse_index_translator_top_assert.svh
// Assertion macros for the synapse index translator checker
`ifndef SYNAPSE_INDEX_TRANSLATOR_TOP_ASSERT_SVH
`define SYNAPSE_INDEX_TRANSLATOR_TOP_ASSERT_SVH

// same-cycle implication
`define SIT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/sit_pkg.sv
// Shared types and codes of the synapse index translator
package sit_pkg;

   localparam logic [1:0] CMD_LOAD_DIM   = 2'd0;
   localparam logic [1:0] CMD_LOAD_LAYER = 2'd1;
   localparam logic [1:0] CMD_CHECK      = 2'd2;

   localparam logic [2:0] ST_LOADED    = 3'd0;
   localparam logic [2:0] ST_OK        = 3'd1;
   localparam logic [2:0] ST_END       = 3'd2;
   localparam logic [2:0] ST_AFTER_END = 3'd3;
   localparam logic [2:0] ST_BAD_LAYER = 3'd4;
   localparam logic [2:0] ST_BAD_INDEX = 3'd5;
   localparam logic [2:0] ST_BAD_TYPE  = 3'd6;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  layer_sel;
      logic [2:0]  dim_sel;
      logic [15:0] extent;
      logic [15:0] padded_extent;
      logic [2:0]  perm_source;
      logic [3:0]  dim_count;
      logic [3:0]  split_dim;
      logic        layer_ok;
      logic [31:0] syn_index;
      logic [15:0] syn_layer;
      logic [15:0] syn_type;
   } item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] out_x;
      logic [15:0] out_y;
      logic [3:0]  out_layer;
      logic [15:0] out_type;
      logic        last_slot;
      logic [10:0] synapse_count;
   } result_type;

   typedef struct packed {
      logic [4:0]  layer_count;
      logic [10:0] slots_per_neuron;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quo;
      logic [31:0] rem;
   } div_rsp_type;

endpackage

>>> hw/rtl/sit_div.sv
// Iterative restoring divider, one quotient bit per cycle
module sit_div (
   input  logic                clock,
   input  logic                reset,
   input  sit_pkg::div_req_type req,
   output sit_pkg::div_rsp_type rsp
);
   import sit_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [33:0] trial;
   logic        ge;

   assign trial = {1'b0, rem_ff, quo_ff[31]} - {2'b00, dvs_ff};
   assign ge    = !trial[33];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         dvs_in = req.divisor;
         if (req.divisor == 32'd0) begin
            quo_in  = 32'd0;
            rem_in  = req.dividend;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            cnt_in  = 5'd31;
            rem_in  = 32'd0;
            quo_in  = req.dividend;
         end
      end else if (busy_ff) begin
         rem_in = ge ? trial[31:0] : {rem_ff[30:0], quo_ff[31]};
         quo_in = {quo_ff[30:0], ge};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
   assign rsp.rem  = rem_ff;

endmodule

>>> hw/rtl/sit_ctrl.sv
// Sequencer with layout memories, coordinate split and recomposition
module sit_ctrl #(
   parameter int MAX_LAYERS = 16,
   parameter int MAX_DIMS   = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  sit_pkg::item_type    item,
   input  sit_pkg::cfg_type     cfg,
   input  logic                 out_free,
   output logic                 idle,
   output logic                 rsp_load,
   output sit_pkg::result_type  rsp
);
   import sit_pkg::*;

   localparam int LW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int DEPTH = MAX_LAYERS * MAX_DIMS;
   localparam int AW    = $clog2(DEPTH);
   localparam int DW    = $clog2(MAX_DIMS);

   typedef struct packed {
      logic [31:0] cum;
      logic [15:0] pad;
      logic [2:0]  perm;
   } dent_type;

   typedef struct packed {
      logic [3:0]  dims;
      logic [3:0]  split;
      logic [31:0] elems;
   } lent_type;

   typedef enum logic [11:0] {
      S_IDLE    = 12'b000000000001,
      S_RD      = 12'b000000000010,
      S_DIM_WR  = 12'b000000000100,
      S_LAY_WR  = 12'b000000001000,
      S_CHK     = 12'b000000010000,
      S_DIV_RD  = 12'b000000100000,
      S_DIV_GO  = 12'b000001000000,
      S_DIV_WT  = 12'b000010000000,
      S_REC_SET = 12'b000100000000,
      S_REC_RD  = 12'b001000000000,
      S_REC_MAC = 12'b010000000000,
      S_FIN     = 12'b100000000000
   } state_type;

   dent_type dmem [DEPTH];
   lent_type lmem [MAX_LAYERS];
   dent_type mrd_ff;
   lent_type lrd_ff;

   state_type state_ff, state_in;
   item_type  it_ff, it_in;
   logic [MAX_LAYERS-1:0] enabled_ff, enabled_in;
   logic [10:0] slot_ff, slot_in;
   logic        end_seen_ff, end_seen_in;
   logic [10:0] valid_ff, valid_in;
   logic        end_now_ff, end_now_in;
   logic [2:0]  status_ff, status_in;
   logic [AW-1:0] base_ff, base_in;
   logic [31:0] e_ff, e_in;
   logic [3:0]  d1_ff, d1_in;
   logic [3:0]  d2_ff, d2_in;
   logic [DW-1:0] d_ff, d_in;
   logic [DW-1:0] k_ff, k_in;
   logic [DW-1:0] klow_ff, klow_in;
   logic        phx_ff, phx_in;
   logic        first_ff, first_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] x_ff, x_in;
   logic [31:0] y_ff, y_in;
   logic [31:0] c2_ff [MAX_DIMS];
   logic [31:0] c2_in [MAX_DIMS];

   logic [AW-1:0] l_base, dim_addr, lay_last, maddr;
   logic [LW-1:0] lsel_idx, slot_lidx;
   logic [3:0]  nd_sat, sp_lim, sp_sat;
   logic        lsel_ok, dsel_ok;
   logic [15:0] pz_m1;
   logic [31:0] pe_m1;
   logic        end_now, layer_bad;
   logic [47:0] dim_prod, rec_prod;
   logic [31:0] cval, accn;
   logic        dmem_we, lmem_we;
   dent_type    dwr;
   logic [10:0] spn_eff, vcount_n;
   logic        slot_last, ok;
   div_req_type dreq;
   div_rsp_type drsp;

   sit_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   assign l_base    = AW'(32'(it_ff.layer_sel) * MAX_DIMS);
   assign dim_addr  = l_base + AW'(it_ff.dim_sel);
   assign lsel_idx  = LW'(it_ff.layer_sel);
   assign lsel_ok   = 7'(it_ff.layer_sel) < 7'(MAX_LAYERS);
   assign dsel_ok   = 4'(it_ff.dim_sel) < 4'(MAX_DIMS);
   assign pz_m1     = it_ff.syn_layer - 16'd1;
   assign pe_m1     = it_ff.syn_index - 32'd1;
   assign slot_lidx = LW'(pz_m1);

   always_comb begin
      priority if (it_ff.dim_count == 4'd0) nd_sat = 4'd1;
      else if (it_ff.dim_count > 4'(MAX_DIMS)) nd_sat = 4'(MAX_DIMS);
      else nd_sat = it_ff.dim_count;
      priority if (it_ff.split_dim == 4'd0) sp_lim = 4'd1;
      else if (it_ff.split_dim > 4'(MAX_DIMS)) sp_lim = 4'(MAX_DIMS);
      else sp_lim = it_ff.split_dim;
      sp_sat = (sp_lim > nd_sat) ? nd_sat : sp_lim;
   end

   assign lay_last = l_base + AW'(nd_sat - 4'd1);

   always_comb begin
      priority if (state_ff == S_RD && it_ff.cmd == CMD_LOAD_LAYER) maddr = lay_last;
      else if (state_ff == S_RD) maddr = dim_addr - AW'(1);
      else if (state_ff == S_DIV_RD) maddr = base_ff + AW'(d_ff) - AW'(1);
      else maddr = base_ff + AW'(k_ff);
   end

   assign dim_prod = 48'(mrd_ff.cum) * 48'(it_ff.extent);
   assign dwr.cum  = (it_ff.dim_sel == 3'd0) ? 32'(it_ff.extent) : dim_prod[31:0];
   assign dwr.pad  = it_ff.padded_extent;
   assign dwr.perm = it_ff.perm_source;
   assign dmem_we  = (state_ff == S_DIM_WR);
   assign lmem_we  = (state_ff == S_LAY_WR);

   always_ff @(posedge clock) begin
      if (dmem_we) dmem[dim_addr] <= dwr;
      mrd_ff <= dmem[maddr];
   end

   always_ff @(posedge clock) begin
      if (lmem_we) lmem[lsel_idx] <= '{dims: nd_sat, split: sp_sat, elems: mrd_ff.cum};
      lrd_ff <= lmem[slot_lidx];
   end

   assign end_now   = end_seen_ff || (it_ff.syn_index == 32'd0);
   assign layer_bad = (it_ff.syn_layer == 16'd0) ||
                      (it_ff.syn_layer > 16'(cfg.layer_count)) ||
                      (it_ff.syn_layer > 16'(MAX_LAYERS)) ||
                      !enabled_ff[slot_lidx];

   assign cval     = (4'(mrd_ff.perm) < d2_ff) ? c2_ff[DW'(mrd_ff.perm)] : 32'd0;
   assign rec_prod = 48'(acc_ff) * 48'(mrd_ff.pad);
   assign accn     = first_ff ? cval : rec_prod[31:0] + cval;

   assign ok        = (status_ff == ST_OK);
   assign spn_eff   = (cfg.slots_per_neuron == 11'd0) ? 11'd1 : cfg.slots_per_neuron;
   assign vcount_n  = valid_ff + 11'(ok);
   assign slot_last = (12'(slot_ff) + 12'd1) >= 12'(spn_eff);

   always_comb begin
      state_in    = state_ff;
      it_in       = it_ff;
      enabled_in  = enabled_ff;
      slot_in     = slot_ff;
      end_seen_in = end_seen_ff;
      valid_in    = valid_ff;
      end_now_in  = end_now_ff;
      status_in   = status_ff;
      base_in     = base_ff;
      e_in        = e_ff;
      d1_in       = d1_ff;
      d2_in       = d2_ff;
      d_in        = d_ff;
      k_in        = k_ff;
      klow_in     = klow_ff;
      phx_in      = phx_ff;
      first_in    = first_ff;
      acc_in      = acc_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      c2_in       = c2_ff;
      dreq.start    = 1'b0;
      dreq.dividend = e_ff;
      dreq.divisor  = mrd_ff.cum;
      rsp_load    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               it_in    = item;
               state_in = S_RD;
            end
         end
         S_RD: begin
            status_in = ST_LOADED;
            priority if (it_ff.cmd == CMD_LOAD_DIM && lsel_ok && dsel_ok) state_in = S_DIM_WR;
            else if (it_ff.cmd == CMD_LOAD_LAYER && lsel_ok) state_in = S_LAY_WR;
            else if (it_ff.cmd == CMD_CHECK) state_in = S_CHK;
            else state_in = S_FIN;
         end
         S_DIM_WR: state_in = S_FIN;
         S_LAY_WR: begin
            enabled_in[lsel_idx] = it_ff.layer_ok;
            state_in = S_FIN;
         end
         S_CHK: begin
            end_now_in = end_now;
            base_in    = AW'(32'(pz_m1) * MAX_DIMS);
            e_in       = pe_m1;
            d1_in      = lrd_ff.split;
            d2_in      = lrd_ff.dims;
            d_in       = DW'(lrd_ff.dims - 4'd1);
            state_in   = S_FIN;
            priority if (end_now) begin
               status_in = (it_ff.syn_index != 32'd0 || it_ff.syn_layer != 16'd0 ||
                            it_ff.syn_type != 16'd0) ? ST_AFTER_END : ST_END;
            end else if (layer_bad) begin
               status_in = ST_BAD_LAYER;
            end else if (pe_m1 >= lrd_ff.elems) begin
               status_in = ST_BAD_INDEX;
            end else if (it_ff.syn_type == 16'd0) begin
               status_in = ST_BAD_TYPE;
            end else begin
               status_in = ST_OK;
               c2_in[0]  = pe_m1;
               state_in  = (lrd_ff.dims == 4'd1) ? S_REC_SET : S_DIV_RD;
            end
         end
         S_DIV_RD: state_in = S_DIV_GO;
         S_DIV_GO: begin
            dreq.start = 1'b1;
            state_in   = S_DIV_WT;
         end
         S_DIV_WT: begin
            if (drsp.done) begin
               c2_in[d_ff] = drsp.quo;
               e_in        = drsp.rem;
               if (d_ff == DW'(1)) begin
                  c2_in[0] = drsp.rem;
                  state_in = S_REC_SET;
               end else begin
                  d_in     = d_ff - DW'(1);
                  state_in = S_DIV_RD;
               end
            end
         end
         S_REC_SET: begin
            first_in = 1'b1;
            state_in = S_REC_RD;
            if (d1_ff < d2_ff) begin
               phx_in  = 1'b1;
               k_in    = DW'(d2_ff - 4'd1);
               klow_in = DW'(d1_ff);
            end else begin
               phx_in  = 1'b0;
               x_in    = 32'd0;
               k_in    = DW'(d1_ff - 4'd1);
               klow_in = '0;
            end
         end
         S_REC_RD: state_in = S_REC_MAC;
         S_REC_MAC: begin
            acc_in   = accn;
            first_in = 1'b0;
            state_in = S_REC_RD;
            if (k_ff == klow_ff) begin
               if (phx_ff) begin
                  x_in     = accn;
                  phx_in   = 1'b0;
                  first_in = 1'b1;
                  k_in     = DW'(d1_ff - 4'd1);
                  klow_in  = '0;
               end else begin
                  y_in     = accn;
                  state_in = S_FIN;
               end
            end else begin
               k_in = k_ff - DW'(1);
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               if (it_ff.cmd == CMD_CHECK) begin
                  if (slot_last) begin
                     slot_in     = 11'd0;
                     end_seen_in = 1'b0;
                     valid_in    = 11'd0;
                  end else begin
                     slot_in     = slot_ff + 11'd1;
                     end_seen_in = end_now_ff;
                     valid_in    = vcount_n;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp.status        = status_ff;
      rsp.out_x         = ok ? x_ff[15:0] : 16'd0;
      rsp.out_y         = ok ? y_ff[15:0] : 16'd0;
      rsp.out_layer     = ok ? pz_m1[3:0] : 4'd0;
      rsp.out_type      = ok ? (it_ff.syn_type - 16'd1) : 16'd0;
      rsp.last_slot     = (it_ff.cmd == CMD_CHECK) && slot_last;
      rsp.synapse_count = ((it_ff.cmd == CMD_CHECK) && slot_last) ? vcount_n : 11'd0;
   end

   assign idle = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         enabled_ff  <= '0;
         slot_ff     <= 11'd0;
         end_seen_ff <= 1'b0;
         valid_ff    <= 11'd0;
      end else begin
         state_ff    <= state_in;
         enabled_ff  <= enabled_in;
         slot_ff     <= slot_in;
         end_seen_ff <= end_seen_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      it_ff      <= it_in;
      end_now_ff <= end_now_in;
      status_ff  <= status_in;
      base_ff    <= base_in;
      e_ff       <= e_in;
      d1_ff      <= d1_in;
      d2_ff      <= d2_in;
      d_ff       <= d_in;
      k_ff       <= k_in;
      klow_ff    <= klow_in;
      phx_ff     <= phx_in;
      first_ff   <= first_in;
      acc_ff     <= acc_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      c2_ff      <= c2_in;
   end

endmodule

>>> hw/rtl/synapse_index_translator_top.sv
// Top level of the synapse index translator: ports, CSRs and result register
//
// Usage: load layouts first, one dimension entry per req transfer with cmd 0
// (dimensions of a layer in ascending order), then one layer entry with cmd 1.
// Then send synapse slots with cmd 2; each slot gives one rsp transfer with
// a status, the zero-based x, y, layer and type, and on a neuron's final
// slot last_slot with the count of good synapses.
// layer_count and slots_per_neuron are to be written over the APB port only while idle; the block does not enforce it.
// One item is worked on at a time; req_stall is high while it is in flight.
// Loads and rejected slots pass S_RD, a write or check state and S_FIN; the unused
// command 3 goes from S_RD straight to S_FIN; each then returns to S_IDLE.
// A good slot of a layer with n dimensions runs each of its n-1 index splits on
// the shared iterative divider, and each recomposition step is one layout-memory
// read plus one multiply-add.
// The result register holds a finished result while rsp_stall is high; the
// next item is already taken and waits only at its own end for that register.
// Reset clears the layer enables, the per-neuron slot state, layer_count
// (to 0) and slots_per_neuron (to 1); layout memories keep stale contents.
module synapse_index_translator_top #(
   parameter int MAX_LAYERS = 16,
   parameter int MAX_DIMS   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [3:0]  req_layer_sel,
   input  logic [2:0]  req_dim_sel,
   input  logic [15:0] req_extent,
   input  logic [15:0] req_padded_extent,
   input  logic [2:0]  req_perm_source,
   input  logic [3:0]  req_dim_count,
   input  logic [3:0]  req_split_dim,
   input  logic        req_layer_ok,
   input  logic [31:0] req_syn_index,
   input  logic [15:0] req_syn_layer,
   input  logic [15:0] req_syn_type,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_out_x,
   output logic [15:0] rsp_out_y,
   output logic [3:0]  rsp_out_layer,
   output logic [15:0] rsp_out_type,
   output logic        rsp_last_slot,
   output logic [10:0] rsp_synapse_count,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import sit_pkg::*;

   localparam logic REG_LAYER_COUNT = 1'b0;

   cfg_type    cfg_ff, cfg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type res_ff, res_in;
   result_type res_new;
   item_type   item;
   logic       idle, accept, out_free, rsp_load, wr_en;

   assign item = '{cmd: req_cmd, layer_sel: req_layer_sel, dim_sel: req_dim_sel,
                   extent: req_extent, padded_extent: req_padded_extent,
                   perm_source: req_perm_source, dim_count: req_dim_count,
                   split_dim: req_split_dim, layer_ok: req_layer_ok,
                   syn_index: req_syn_index, syn_layer: req_syn_layer,
                   syn_type: req_syn_type};

   assign req_stall = !idle;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   sit_ctrl #(
      .MAX_LAYERS (MAX_LAYERS),
      .MAX_DIMS   (MAX_DIMS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (item),
      .cfg      (cfg_ff),
      .out_free (out_free),
      .idle     (idle),
      .rsp_load (rsp_load),
      .rsp      (res_new)
   );

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         if (paddr[2] == REG_LAYER_COUNT) cfg_in.layer_count = pwdata[4:0];
         else cfg_in.slots_per_neuron = pwdata[10:0];
      end
      prdata = (paddr[2] == REG_LAYER_COUNT) ? 32'(cfg_ff.layer_count)
                                             : 32'(cfg_ff.slots_per_neuron);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      res_in       = res_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         res_in       = res_new;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{layer_count: 5'd0, slots_per_neuron: 11'd1};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = res_ff.status;
   assign rsp_out_x         = res_ff.out_x;
   assign rsp_out_y         = res_ff.out_y;
   assign rsp_out_layer     = res_ff.out_layer;
   assign rsp_out_type      = res_ff.out_type;
   assign rsp_last_slot     = res_ff.last_slot;
   assign rsp_synapse_count = res_ff.synapse_count;

endmodule

>>> hw/rtl/sit_checker.sv
// Port-level checker for the synapse index translator, bound to the top level
`include "synapse_index_translator_top_assert.svh"

module sit_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_out_x,
   input logic [15:0] rsp_out_y,
   input logic [3:0]  rsp_out_layer,
   input logic [15:0] rsp_out_type,
   input logic        rsp_last_slot,
   input logic [10:0] rsp_synapse_count
);
   import sit_pkg::*;

   `SIT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "rsp dropped while stalled")
   `SIT_ASSERT_NEXT(a_busy_after, req_valid && !req_stall, req_stall, "no busy after transfer")
   `SIT_ASSERT_NOW(a_fields_zero, rsp_valid && rsp_status != ST_OK, rsp_out_x == 16'd0 && rsp_out_y == 16'd0 && rsp_out_layer == 4'd0 && rsp_out_type == 16'd0, "fields set on non-ok result")
   `SIT_ASSERT_NOW(a_count_last, rsp_valid && !rsp_last_slot, rsp_synapse_count == 11'd0, "count without last slot")
   `SIT_ASSERT_NOW(a_load_nolast, rsp_valid && rsp_status == ST_LOADED, !rsp_last_slot, "last slot on load")

endmodule

bind synapse_index_translator_top sit_checker u_sit_checker (.*);

>>> test/tb_synapse_index_translator_top.sv
// Testbench for the synapse index translator: directed table, random slots, predictor check
module tb_synapse_index_translator_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sit_pkg::*;

   localparam int N_LAYERS    = 16;
   localparam int N_DIMS      = 8;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 500;
   localparam int DRAIN_WAIT  = 300;
   localparam logic [2:0] ADDR_LAYER_COUNT = 3'd0;
   localparam logic [2:0] ADDR_SLOTS       = 3'd4;
   localparam logic [1:0] CMD_UNUSED       = 2'd3;

   typedef struct {
      item_type   it;
      bit         typed;
      result_type res;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   wire result_type rsp_item;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   synapse_index_translator_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_item.cmd), .req_layer_sel(req_item.layer_sel),
      .req_dim_sel(req_item.dim_sel), .req_extent(req_item.extent),
      .req_padded_extent(req_item.padded_extent), .req_perm_source(req_item.perm_source),
      .req_dim_count(req_item.dim_count), .req_split_dim(req_item.split_dim),
      .req_layer_ok(req_item.layer_ok), .req_syn_index(req_item.syn_index),
      .req_syn_layer(req_item.syn_layer), .req_syn_type(req_item.syn_type),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_item.status), .rsp_out_x(rsp_item.out_x),
      .rsp_out_y(rsp_item.out_y), .rsp_out_layer(rsp_item.out_layer),
      .rsp_out_type(rsp_item.out_type), .rsp_last_slot(rsp_item.last_slot),
      .rsp_synapse_count(rsp_item.synapse_count),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // layout and slot state mirrored from the block
   logic [31:0] cum_extent [N_LAYERS*N_DIMS];
   logic [15:0] pad_size   [N_LAYERS*N_DIMS];
   logic [2:0]  perm_src   [N_LAYERS*N_DIMS];
   logic [3:0]  lay_dims   [N_LAYERS];
   logic [3:0]  lay_split  [N_LAYERS];
   logic [31:0] lay_elems  [N_LAYERS];
   logic        lay_on     [N_LAYERS];
   logic [10:0] slot_pos, good_slots;
   logic        list_ended;
   logic [4:0]  cfg_layers;
   logic [10:0] cfg_slots;

   result_type expected_q[$];
   int  mismatches = 0;
   int  cycles = 0;
   int  tx_idle_pct = 0, rx_idle_pct = 0;
   bit  hold_go = 0;
   int  hold_left = HOLD_CYCLES;

   function automatic result_type translate_item(item_type it);
      result_type r;
      logic [31:0] c2[N_DIMS], c3[N_DIMS];
      logic [31:0] e, dv, q, x, y;
      int b, d2, d1, nd, sp, idx;
      logic [31:0] pe, pz, pt;
      r = '0;
      b = int'(it.layer_sel) * N_DIMS;
      case (it.cmd)
         CMD_LOAD_DIM: begin
            idx = b + int'(it.dim_sel);
            cum_extent[idx] = (it.dim_sel == 0) ? {16'd0, it.extent}
                              : cum_extent[idx-1] * {16'd0, it.extent};
            pad_size[idx] = it.padded_extent;
            perm_src[idx] = it.perm_source;
         end
         CMD_LOAD_LAYER: begin
            nd = (it.dim_count < 1) ? 1 : (it.dim_count > N_DIMS) ? N_DIMS
                 : int'(it.dim_count);
            sp = (it.split_dim < 1) ? 1 : int'(it.split_dim);
            if (sp > nd) sp = nd;
            lay_dims[it.layer_sel]  = 4'(nd);
            lay_split[it.layer_sel] = 4'(sp);
            lay_on[it.layer_sel]    = it.layer_ok;
            lay_elems[it.layer_sel] = cum_extent[b + nd - 1];
         end
         CMD_CHECK: begin
            pe = it.syn_index;
            pz = 32'(it.syn_layer);
            pt = 32'(it.syn_type);
            if (!list_ended && pe == 0) list_ended = 1'b1;
            if (list_ended) begin
               r.status = (pe != 0 || pz != 0 || pt != 0) ? ST_AFTER_END : ST_END;
            end else if (pz == 0 || pz > cfg_layers || pz > N_LAYERS || !lay_on[pz-1]) begin
               r.status = ST_BAD_LAYER;
            end else if (pe - 1 >= lay_elems[pz-1]) begin
               r.status = ST_BAD_INDEX;
            end else if (pt == 0) begin
               r.status = ST_BAD_TYPE;
            end else begin
               b  = int'(pz - 1) * N_DIMS;
               d2 = int'(lay_dims[pz-1]);
               d1 = int'(lay_split[pz-1]);
               e  = pe - 1;
               for (int d = 0; d < N_DIMS; d++) begin
                  c2[d] = 0;
                  c3[d] = 0;
               end
               for (int d = d2 - 1; d > 0; d--) begin
                  dv = cum_extent[b+d-1];
                  q  = (dv != 0) ? e / dv : 0;
                  c2[d] = q;
                  e = e - q * dv;
               end
               c2[0] = e;
               for (int d = 0; d < d2; d++)
                  c3[d] = (int'(perm_src[b+d]) < d2) ? c2[perm_src[b+d]] : 0;
               x = 0;
               if (d1 < d2) begin
                  x = c3[d2-1];
                  for (int d = d2 - 1; d > d1; d--)
                     x = x * {16'd0, pad_size[b+d-1]} + c3[d-1];
               end
               y = c3[d1-1];
               for (int d = d1 - 1; d > 0; d--)
                  y = y * {16'd0, pad_size[b+d-1]} + c3[d-1];
               r.status    = ST_OK;
               r.out_x     = x[15:0];
               r.out_y     = y[15:0];
               r.out_layer = pz[3:0] - 4'd1;
               r.out_type  = pt[15:0] - 16'd1;
               good_slots  = good_slots + 11'd1;
            end
            if (32'(slot_pos) + 1 >= ((cfg_slots == 0) ? 1 : 32'(cfg_slots))) begin
               r.last_slot     = 1'b1;
               r.synapse_count = good_slots;
               slot_pos   = 11'd0;
               list_ended = 1'b0;
               good_slots = 11'd0;
            end else begin
               slot_pos = slot_pos + 11'd1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic item_type dim_item(int l, int d, int ext, int pad, int pm);
      item_type it = '0;
      it.cmd = CMD_LOAD_DIM;
      it.layer_sel = 4'(l);
      it.dim_sel = 3'(d);
      it.extent = 16'(ext);
      it.padded_extent = 16'(pad);
      it.perm_source = 3'(pm);
      return it;
   endfunction

   function automatic item_type layer_item(int l, int nd, int sp, bit ok);
      item_type it = '0;
      it.cmd = CMD_LOAD_LAYER;
      it.layer_sel = 4'(l);
      it.dim_count = 4'(nd);
      it.split_dim = 4'(sp);
      it.layer_ok = ok;
      return it;
   endfunction

   function automatic item_type slot_item(logic [31:0] idx, int lay, int typ);
      item_type it = '0;
      it.cmd = CMD_CHECK;
      it.syn_index = idx;
      it.syn_layer = 16'(lay);
      it.syn_type = 16'(typ);
      return it;
   endfunction

   function automatic result_type plain_result(logic [2:0] st, bit last);
      result_type r = '0;
      r.status = st;
      r.last_slot = last;
      return r;
   endfunction

   task automatic send(item_type it, bit typed, result_type res);
      result_type pred;
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         req_item  <= item_type'(133'({$urandom, $urandom, $urandom, $urandom, $urandom}));
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      pred = translate_item(it);
      expected_q.push_back(typed ? res : pred);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (addr == ADDR_LAYER_COUNT) cfg_layers = data[4:0];
      else cfg_slots = data[10:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic reload_layer();
      int l, raw_nd, nd, ext, r;
      l = $urandom_range(N_LAYERS - 1);
      raw_nd = $urandom_range(15);
      nd = (raw_nd < 1) ? 1 : (raw_nd > N_DIMS) ? N_DIMS : raw_nd;
      for (int d = 0; d < nd; d++) begin
         r = $urandom_range(99);
         ext = (r < 80) ? $urandom_range(1, 5) : (r < 92) ? $urandom_range(1, 65535) : 65535;
         send(dim_item(l, d, ext, ($urandom_range(3) == 0) ? $urandom_range(1, 65535)
                       : $urandom_range(1, 9), $urandom_range(7)), 0, '0);
      end
      send(layer_item(l, raw_nd, $urandom_range(15), $urandom_range(99) < 85), 0, '0);
   endtask

   task automatic random_slot();
      item_type it;
      int lay, r;
      logic [31:0] idx;
      r = $urandom_range(99);
      if (list_ended) begin
         it = (r < 85) ? slot_item(0, 0, 0)
              : slot_item($urandom_range(1) ? $urandom : 0, $urandom_range(65535),
                          $urandom_range(65535));
      end else if (r < 8) begin
         it = slot_item(0, 0, 0);
      end else if (r < 13) begin
         it = slot_item($urandom, $urandom_range(65535), $urandom_range(65535));
      end else begin
         lay = $urandom_range(1, (cfg_layers == 0) ? 1 : cfg_layers);
         if (lay_elems[lay-1] == 0 || $urandom_range(9) == 0)
            idx = $urandom;
         else
            idx = 32'($urandom_range(lay_elems[lay-1] - 1)) + 1;
         it = slot_item(idx, lay, ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 65535));
      end
      send(it, 0, '0);
   endtask

   always @(negedge clock) begin
      if (hold_go && hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer: %p", rsp_item);
         end else begin
            want = expected_q.pop_front();
            if (rsp_item.status !== want.status || rsp_item.out_x !== want.out_x ||
                rsp_item.out_y !== want.out_y || rsp_item.out_layer !== want.out_layer ||
                rsp_item.out_type !== want.out_type || rsp_item.last_slot !== want.last_slot ||
                rsp_item.synapse_count !== want.synapse_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, rsp_item);
            end
         end
      end
   end

   initial begin
      row_type rows[$];
      row_type rw;
      int lc_set[4] = '{16, 9, 16, 0};
      int sp_set[4] = '{7, 1024, 3, 1};
      int cnt_set[4] = '{330, 330, 320, 15};
      int tx_set[4] = '{19, 71, 0, 0};
      int rx_set[4] = '{71, 19, 0, 0};
      for (int i = 0; i < N_LAYERS; i++) lay_on[i] = 0;
      for (int i = 0; i < N_LAYERS; i++) lay_elems[i] = 0;
      slot_pos = 0;
      good_slots = 0;
      list_ended = 0;
      cfg_layers = 0;
      cfg_slots = 1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_write(ADDR_LAYER_COUNT, 16);
      csr_write(ADDR_SLOTS, 1);
      rows.push_back('{dim_item(0, 0, 3, 4, 1), 1, plain_result(ST_LOADED, 0)});
      rows.push_back('{dim_item(0, 1, 5, 8, 0), 1, plain_result(ST_LOADED, 0)});
      rows.push_back('{dim_item(0, 2, 2, 2, 2), 1, plain_result(ST_LOADED, 0)});
      rows.push_back('{layer_item(0, 3, 1, 1), 1, plain_result(ST_LOADED, 0)});
      rows.push_back('{dim_item(15, 0, 65535, 65535, 7), 1, plain_result(ST_LOADED, 0)});
      rows.push_back('{dim_item(15, 1, 256, 1, 0), 1, plain_result(ST_LOADED, 0)});
      rows.push_back('{layer_item(15, 2, 15, 0), 1, plain_result(ST_LOADED, 0)});
      rw.it = '1;
      rw.it.cmd = CMD_UNUSED;
      rows.push_back('{rw.it, 1, plain_result(ST_LOADED, 0)});
      rows.push_back('{slot_item(1, 0, 1), 1, plain_result(ST_BAD_LAYER, 1)});
      rows.push_back('{slot_item(1, 17, 1), 1, plain_result(ST_BAD_LAYER, 1)});
      rows.push_back('{slot_item(1, 2, 1), 1, plain_result(ST_BAD_LAYER, 1)});
      rows.push_back('{slot_item(1, 16, 1), 1, plain_result(ST_BAD_LAYER, 1)});
      rows.push_back('{slot_item(1, 65535, 1), 1, plain_result(ST_BAD_LAYER, 1)});
      rows.push_back('{slot_item(1, 1, 1), 0, '0});
      rows.push_back('{slot_item(30, 1, 65535), 0, '0});
      rows.push_back('{slot_item(17, 1, 2), 0, '0});
      rows.push_back('{slot_item(31, 1, 1), 1, plain_result(ST_BAD_INDEX, 1)});
      rows.push_back('{slot_item(32'hFFFF_FFFF, 1, 1), 1, plain_result(ST_BAD_INDEX, 1)});
      rows.push_back('{slot_item(5, 1, 0), 1, plain_result(ST_BAD_TYPE, 1)});
      rows.push_back('{slot_item(0, 0, 0), 1, plain_result(ST_END, 1)});
      rows.push_back('{slot_item(0, 65535, 65535), 1, plain_result(ST_AFTER_END, 1)});
      foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].res);

      for (int p = 0; p < 4; p++) begin
         @(negedge clock);
         req_valid <= 1'b0;
         wait (expected_q.size() == 0);
         csr_write(ADDR_LAYER_COUNT, lc_set[p]);
         csr_write(ADDR_SLOTS, sp_set[p]);
         tx_idle_pct = tx_set[p];
         rx_idle_pct = rx_set[p];
         if (p == 2) hold_go = 1;
         reload_layer();
         for (int n = 0; n < cnt_set[p]; n++) begin
            if ($urandom_range(99) < 7) reload_layer();
            else if ($urandom_range(99) < 3) begin
               rw.it = item_type'(133'({$urandom, $urandom, $urandom, $urandom, $urandom}));
               rw.it.cmd = CMD_UNUSED;
               send(rw.it, 0, '0);
            end
            else random_slot();
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/sit_pkg.sv
hw/rtl/sit_div.sv
hw/rtl/sit_ctrl.sv
hw/rtl/synapse_index_translator_top.sv
hw/rtl/sit_checker.sv
test/tb_synapse_index_translator_top.sv
